FILE: hdl/oplbp_pkg.sv
// oplbp_pkg: codes, register indexes and reset values of the output pin driver
// used by output_pin_lock_blink_pulse, tb_pin_checker and tb_top; depends on nothing
package oplbp_pkg;

    localparam int TIME_W    = 32;
    localparam int ON_OFF_W  = 16;
    localparam int MODE_W    = 3;
    localparam int ACTION_W  = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [TIME_W-1:0] TIMER_IDLE = '1;

    // event kinds
    localparam logic [KIND_W-1:0] EV_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] EV_SWITCH = 2'd1;
    localparam logic [KIND_W-1:0] EV_BLINK  = 2'd2;
    localparam logic [KIND_W-1:0] EV_LOCK   = 2'd3;

    // blink modes
    localparam logic [MODE_W-1:0] MODE_NEVER      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IF_OFF     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IF_ON      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OBJECT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OBJ_AND_OFF = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OBJ_AND_ON = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ALWAYS     = 3'd6;
    localparam logic [MODE_W-1:0] MODE_PULSE      = 3'd7;

    // lock actions
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_OFF    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ON     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUT   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_INVERT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_RESUME  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_SW_ACT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_BL_ACT  = 4'd7;

    localparam logic [ON_OFF_W-1:0] ON_TIME_RESET  = 16'd500;
    localparam logic [ON_OFF_W-1:0] OFF_TIME_RESET = 16'd500;

    function automatic logic apply_action(input logic [ACTION_W-1:0] act, input logic cur);
        logic r;
        begin
            case (act)
                ACT_OFF: r = 1'b0;
                ACT_ON:  r = 1'b1;
                default: r = !cur;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hdl/output_pin_lock_blink_pulse.sv
// output_pin_lock_blink_pulse: top level of the output pin driver with lock, blink and pulse
// depends on oplbp_pkg; checked by oplbp_checker (bound from its own file)

// One item is taken per clock cycle while the result side does not stall. An accepted
// item is held in the input register, is evaluated there against the stored switch,
// blink, lock and timer state, and its result lands in the result register when
// that register is empty or its result is taken; with out_ready held high items
// flow at one per cycle. The critical path is the timer: an add of the
// pulse length, the expiry compare against now_ms and the phase-time add.
// Configuration writes are taken every cycle (cfg_ready is always high) and are
// meant to be made while no item is in flight.
module output_pin_lock_blink_pulse (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [oplbp_pkg::KIND_W-1:0]      event_kind,
    input  logic                              obj_value,
    input  logic [oplbp_pkg::TIME_W-1:0]      now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              pin_level,
    output logic                              switch_write,
    output logic                              switch_value,
    output logic                              blink_write,
    output logic                              blink_value,
    output logic                              status_write,
    output logic                              status_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [oplbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [oplbp_pkg::CFG_DAT_W-1:0]   cfg_data
);

    // configuration
    logic [oplbp_pkg::MODE_W-1:0]   blink_mode_reg;
    logic [oplbp_pkg::ON_OFF_W-1:0] on_time_reg;
    logic [oplbp_pkg::ON_OFF_W-1:0] off_time_reg;
    logic                           invert_out_reg;
    logic                           lock_invert_reg;
    logic                           lock_resume_reg;
    logic [oplbp_pkg::ACTION_W-1:0] lock_sw_act_reg;
    logic [oplbp_pkg::ACTION_W-1:0] lock_bl_act_reg;

    // input register
    logic                           in_valid_reg;
    logic [oplbp_pkg::KIND_W-1:0]   kind_reg;
    logic                           value_reg;
    logic [oplbp_pkg::TIME_W-1:0]   now_reg;

    // block state
    logic                           switch_state_reg,  switch_state_next;
    logic                           blink_en_reg,      blink_en_next;
    logic                           blink_phase_reg,   blink_phase_next;
    logic                           lock_engaged_reg,  lock_engaged_next;
    logic                           sw_held_reg,       sw_held_next;
    logic                           bl_held_reg,       bl_held_next;
    logic                           status_shadow_reg, status_shadow_next;
    logic [oplbp_pkg::TIME_W-1:0]   next_action_reg,   next_action_next;

    // result register
    logic out_valid_reg, out_valid_next;
    logic level_reg,     level_next;
    logic sw_wr_reg,     sw_wr_next;
    logic sw_val_reg,    sw_val_next;
    logic bl_wr_reg,     bl_wr_next;
    logic bl_val_reg,    bl_val_next;
    logic st_wr_reg,     st_wr_next;
    logic st_val_reg,    st_val_next;

    logic advance;
    logic blink_active;
    logic sw_mid;
    logic [oplbp_pkg::TIME_W-1:0] nat_mid;
    logic [oplbp_pkg::TIME_W-1:0] phase_add;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_mode_reg  <= oplbp_pkg::MODE_NEVER;
            on_time_reg     <= oplbp_pkg::ON_TIME_RESET;
            off_time_reg    <= oplbp_pkg::OFF_TIME_RESET;
            invert_out_reg  <= 1'b0;
            lock_invert_reg <= 1'b0;
            lock_resume_reg <= 1'b0;
            lock_sw_act_reg <= oplbp_pkg::ACT_NONE;
            lock_bl_act_reg <= oplbp_pkg::ACT_NONE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                oplbp_pkg::REG_BLINK_MODE:
                    blink_mode_reg <= cfg_data[oplbp_pkg::MODE_W-1:0];
                oplbp_pkg::REG_ON_TIME:     on_time_reg     <= cfg_data;
                oplbp_pkg::REG_OFF_TIME:    off_time_reg    <= cfg_data;
                oplbp_pkg::REG_INVERT_OUT:  invert_out_reg  <= cfg_data[0];
                oplbp_pkg::REG_LOCK_INVERT: lock_invert_reg <= cfg_data[0];
                oplbp_pkg::REG_LOCK_RESUME: lock_resume_reg <= cfg_data[0];
                oplbp_pkg::REG_LOCK_SW_ACT:
                    lock_sw_act_reg <= cfg_data[oplbp_pkg::ACTION_W-1:0];
                oplbp_pkg::REG_LOCK_BL_ACT:
                    lock_bl_act_reg <= cfg_data[oplbp_pkg::ACTION_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= event_kind;
            value_reg <= obj_value;
            now_reg   <= now_ms;
        end
    end

    always_comb
    begin
        switch_state_next  = switch_state_reg;
        blink_en_next      = blink_en_reg;
        blink_phase_next   = blink_phase_reg;
        lock_engaged_next  = lock_engaged_reg;
        sw_held_next       = sw_held_reg;
        bl_held_next       = bl_held_reg;
        status_shadow_next = status_shadow_reg;
        sw_wr_next         = 1'b0;
        sw_val_next        = 1'b0;
        bl_wr_next         = 1'b0;
        bl_val_next        = 1'b0;
        st_wr_next         = 1'b0;
        st_val_next        = 1'b0;
        blink_active       = 1'b0;

        // object updates and lock handling
        case (kind_reg)
            oplbp_pkg::EV_SWITCH:
            begin
                sw_held_next = value_reg;
                if (!lock_engaged_reg)
                    switch_state_next = value_reg;
            end
            oplbp_pkg::EV_BLINK:
            begin
                bl_held_next = value_reg;
                if (!lock_engaged_reg)
                    blink_en_next = value_reg;
            end
            oplbp_pkg::EV_LOCK:
            begin
                lock_engaged_next = value_reg ^ lock_invert_reg;
                if (lock_engaged_next)
                begin
                    if (lock_sw_act_reg != oplbp_pkg::ACT_NONE)
                    begin
                        switch_state_next = oplbp_pkg::apply_action(lock_sw_act_reg,
                                                                    switch_state_reg);
                        sw_held_next = switch_state_next;
                        sw_wr_next   = 1'b1;
                        sw_val_next  = switch_state_next;
                    end
                    if (lock_bl_act_reg != oplbp_pkg::ACT_NONE)
                    begin
                        blink_en_next = oplbp_pkg::apply_action(lock_bl_act_reg, blink_en_reg);
                        bl_held_next  = blink_en_next;
                        bl_wr_next    = 1'b1;
                        bl_val_next   = blink_en_next;
                    end
                end
                else if (lock_resume_reg)
                begin
                    switch_state_next = sw_held_reg;
                    blink_en_next     = bl_held_reg;
                end
            end
            default: ;
        endcase

        sw_mid = switch_state_next;

        // blink selection and timer arming
        case (blink_mode_reg)
            oplbp_pkg::MODE_NEVER:       blink_active = 1'b0;
            oplbp_pkg::MODE_IF_OFF:      blink_active = !sw_mid;
            oplbp_pkg::MODE_IF_ON:       blink_active = sw_mid;
            oplbp_pkg::MODE_OBJECT:      blink_active = blink_en_next;
            oplbp_pkg::MODE_OBJ_AND_OFF: blink_active = !sw_mid && blink_en_next;
            oplbp_pkg::MODE_OBJ_AND_ON:  blink_active = sw_mid && blink_en_next;
            oplbp_pkg::MODE_ALWAYS:      blink_active = 1'b1;
            default:                     blink_active = 1'b0;
        endcase

        if (blink_mode_reg == oplbp_pkg::MODE_PULSE)
        begin
            if (sw_mid && next_action_reg == oplbp_pkg::TIMER_IDLE)
                nat_mid = now_reg + oplbp_pkg::TIME_W'(on_time_reg);
            else
                nat_mid = next_action_reg;
        end
        else if (blink_active)
            nat_mid = (next_action_reg == oplbp_pkg::TIMER_IDLE) ? now_reg : next_action_reg;
        else
            nat_mid = oplbp_pkg::TIMER_IDLE;

        next_action_next = nat_mid;
        phase_add = oplbp_pkg::TIME_W'(blink_phase_reg ? off_time_reg : on_time_reg);

        // timer expiry: pulse end or one phase step
        if (nat_mid < now_reg)
        begin
            if (blink_mode_reg == oplbp_pkg::MODE_PULSE)
            begin
                if (sw_mid)
                begin
                    next_action_next  = oplbp_pkg::TIMER_IDLE;
                    switch_state_next = 1'b0;
                    sw_wr_next        = 1'b1;
                    sw_val_next       = 1'b0;
                end
            end
            else
            begin
                blink_phase_next = !blink_phase_reg;
                next_action_next = nat_mid + phase_add;
            end
        end

        level_next = (blink_active ? blink_phase_next : switch_state_next) ^ invert_out_reg;

        if (blink_mode_reg != oplbp_pkg::MODE_PULSE && status_shadow_reg != switch_state_next)
        begin
            status_shadow_next = switch_state_next;
            st_wr_next         = 1'b1;
            st_val_next        = switch_state_next;
        end

        out_valid_next = advance || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_state_reg  <= 1'b0;
            blink_en_reg      <= 1'b0;
            blink_phase_reg   <= 1'b0;
            lock_engaged_reg  <= 1'b0;
            sw_held_reg       <= 1'b0;
            bl_held_reg       <= 1'b0;
            status_shadow_reg <= 1'b0;
            next_action_reg   <= oplbp_pkg::TIMER_IDLE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                switch_state_reg  <= switch_state_next;
                blink_en_reg      <= blink_en_next;
                blink_phase_reg   <= blink_phase_next;
                lock_engaged_reg  <= lock_engaged_next;
                sw_held_reg       <= sw_held_next;
                bl_held_reg       <= bl_held_next;
                status_shadow_reg <= status_shadow_next;
                next_action_reg   <= next_action_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg  <= level_next;
            sw_wr_reg  <= sw_wr_next;
            sw_val_reg <= sw_val_next;
            bl_wr_reg  <= bl_wr_next;
            bl_val_reg <= bl_val_next;
            st_wr_reg  <= st_wr_next;
            st_val_reg <= st_val_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pin_level    = level_reg;
    assign switch_write = sw_wr_reg;
    assign switch_value = sw_val_reg;
    assign blink_write  = bl_wr_reg;
    assign blink_value  = bl_val_reg;
    assign status_write = st_wr_reg;
    assign status_value = st_val_reg;

endmodule

FILE: hdl/oplbp_checker.sv
// oplbp_checker: port-level assertions for the output pin driver, bound to the top level
// depends on nothing; sees only the ports of output_pin_lock_blink_pulse
module oplbp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              pin_level,
    input logic                              switch_write,
    input logic                              switch_value,
    input logic                              blink_write,
    input logic                              blink_value,
    input logic                              status_write,
    input logic                              status_value
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pin_level) && $stable(switch_write))
        else $error("result dropped or changed while stalled");

    // a value with no write is reported as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !switch_write |-> !switch_value)
        else $error("switch value without write");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !blink_write |-> !blink_value)
        else $error("blink value without write");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status_write |-> !status_value)
        else $error("status value without write");

    // the input side never stalls while the result side is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind output_pin_lock_blink_pulse oplbp_checker u_oplbp_checker (.*);

FILE: tb/tb_pin_checker.sv
`timescale 1ns / 1ps
// tb_pin_checker: watches the item, result and register channels of the output pin driver,
// predicts every result and compares it field by field; depends on oplbp_pkg
module tb_pin_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [oplbp_pkg::KIND_W-1:0]    event_kind,
    input  logic                            obj_value,
    input  logic [oplbp_pkg::TIME_W-1:0]    now_ms,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            pin_level,
    input  logic                            switch_write,
    input  logic                            switch_value,
    input  logic                            blink_write,
    input  logic                            blink_value,
    input  logic                            status_write,
    input  logic                            status_value,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [oplbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [oplbp_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                              mismatch_count,
    output int                              outstanding
);

    typedef struct packed {
        logic pin;
        logic sw_wr;
        logic sw_val;
        logic bl_wr;
        logic bl_val;
        logic st_wr;
        logic st_val;
    } pin_result_t;

    // indexed by bit position of pin_result_t
    string field_names [0:6] = '{"status_value", "status_write", "blink_value", "blink_write",
                                 "switch_value", "switch_write", "pin_level"};

    // register copies
    logic [oplbp_pkg::MODE_W-1:0]   cfg_mode;
    logic [oplbp_pkg::ON_OFF_W-1:0] cfg_on_ms;
    logic [oplbp_pkg::ON_OFF_W-1:0] cfg_off_ms;
    logic                           cfg_out_inv;
    logic                           cfg_lock_inv;
    logic                           cfg_resume;
    logic [oplbp_pkg::ACTION_W-1:0] cfg_sw_act;
    logic [oplbp_pkg::ACTION_W-1:0] cfg_bl_act;

    // driver state
    logic                         sw_on;
    logic                         blink_en;
    logic                         phase;
    logic                         blinking;
    logic                         locked;
    logic                         sw_held;
    logic                         blink_held;
    logic                         status_seen;
    logic [oplbp_pkg::TIME_W-1:0] action_at;

    pin_result_t pending_pin_results [$];

    task automatic note_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic forced_level(input logic [oplbp_pkg::ACTION_W-1:0] act,
                                          input logic cur);
        if (act == oplbp_pkg::ACT_OFF)
            return 1'b0;
        if (act == oplbp_pkg::ACT_ON)
            return 1'b1;
        return !cur;
    endfunction

    function automatic pin_result_t step_pin_driver(input logic [oplbp_pkg::KIND_W-1:0] kind,
                                                    input logic val,
                                                    input logic [oplbp_pkg::TIME_W-1:0] now);
        pin_result_t r;
        logic        level;
        r = '0;
        case (kind)
            oplbp_pkg::EV_SWITCH:
            begin
                sw_held = val;
                if (!locked)
                    sw_on = val;
            end
            oplbp_pkg::EV_BLINK:
            begin
                blink_held = val;
                if (!locked)
                    blink_en = val;
            end
            oplbp_pkg::EV_LOCK:
            begin
                locked = val ^ cfg_lock_inv;
                if (locked)
                begin
                    if (cfg_sw_act != oplbp_pkg::ACT_NONE)
                    begin
                        sw_on    = forced_level(cfg_sw_act, sw_on);
                        sw_held  = sw_on;
                        r.sw_wr  = 1'b1;
                        r.sw_val = sw_on;
                    end
                    if (cfg_bl_act != oplbp_pkg::ACT_NONE)
                    begin
                        blink_en   = forced_level(cfg_bl_act, blink_en);
                        blink_held = blink_en;
                        r.bl_wr    = 1'b1;
                        r.bl_val   = blink_en;
                    end
                end
                else if (cfg_resume)
                begin
                    sw_on    = sw_held;
                    blink_en = blink_held;
                end
            end
            default: ;
        endcase

        if (cfg_mode == oplbp_pkg::MODE_PULSE)
        begin
            blinking = 1'b0;
            // pulse arms only from an idle timer
            if (sw_on && action_at == oplbp_pkg::TIMER_IDLE)
                action_at = now + oplbp_pkg::TIME_W'(cfg_on_ms);
        end
        else
        begin
            case (cfg_mode)
                oplbp_pkg::MODE_IF_OFF:      blinking = !sw_on;
                oplbp_pkg::MODE_IF_ON:       blinking = sw_on;
                oplbp_pkg::MODE_OBJECT:      blinking = blink_en;
                oplbp_pkg::MODE_OBJ_AND_OFF: blinking = !sw_on && blink_en;
                oplbp_pkg::MODE_OBJ_AND_ON:  blinking = sw_on && blink_en;
                oplbp_pkg::MODE_ALWAYS:      blinking = 1'b1;
                default:                     blinking = 1'b0;
            endcase
            if (!blinking)
                action_at = oplbp_pkg::TIMER_IDLE;
            else if (action_at == oplbp_pkg::TIMER_IDLE)
                action_at = now;
        end

        if (action_at < now)
        begin
            if (cfg_mode == oplbp_pkg::MODE_PULSE)
            begin
                // expired pulse with the switch already off stays expired
                if (sw_on)
                begin
                    action_at = oplbp_pkg::TIMER_IDLE;
                    blinking  = 1'b0;
                    sw_on     = 1'b0;
                    r.sw_wr   = 1'b1;
                    r.sw_val  = 1'b0;
                end
            end
            else
            begin
                // at most one phase change however late the item
                phase     = !phase;
                action_at = action_at + oplbp_pkg::TIME_W'(phase ? cfg_on_ms : cfg_off_ms);
            end
        end

        level = blinking ? phase : sw_on;
        r.pin = level ^ cfg_out_inv;

        if (cfg_mode != oplbp_pkg::MODE_PULSE && status_seen != sw_on)
        begin
            status_seen = sw_on;
            r.st_wr     = 1'b1;
            r.st_val    = sw_on;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pin_result_t got;
        pin_result_t want;
        if (!rst_n)
        begin
            cfg_mode     = oplbp_pkg::MODE_NEVER;
            cfg_on_ms    = oplbp_pkg::ON_TIME_RESET;
            cfg_off_ms   = oplbp_pkg::OFF_TIME_RESET;
            cfg_out_inv  = 1'b0;
            cfg_lock_inv = 1'b0;
            cfg_resume   = 1'b0;
            cfg_sw_act   = oplbp_pkg::ACT_NONE;
            cfg_bl_act   = oplbp_pkg::ACT_NONE;
            sw_on        = 1'b0;
            blink_en     = 1'b0;
            phase        = 1'b0;
            blinking     = 1'b0;
            locked       = 1'b0;
            sw_held      = 1'b0;
            blink_held   = 1'b0;
            status_seen  = 1'b0;
            action_at    = oplbp_pkg::TIMER_IDLE;
            pending_pin_results.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    oplbp_pkg::REG_BLINK_MODE:
                        cfg_mode = cfg_data[oplbp_pkg::MODE_W-1:0];
                    oplbp_pkg::REG_ON_TIME:
                        cfg_on_ms = cfg_data[oplbp_pkg::ON_OFF_W-1:0];
                    oplbp_pkg::REG_OFF_TIME:
                        cfg_off_ms = cfg_data[oplbp_pkg::ON_OFF_W-1:0];
                    oplbp_pkg::REG_INVERT_OUT:  cfg_out_inv  = cfg_data[0];
                    oplbp_pkg::REG_LOCK_INVERT: cfg_lock_inv = cfg_data[0];
                    oplbp_pkg::REG_LOCK_RESUME: cfg_resume   = cfg_data[0];
                    oplbp_pkg::REG_LOCK_SW_ACT:
                        cfg_sw_act = cfg_data[oplbp_pkg::ACTION_W-1:0];
                    oplbp_pkg::REG_LOCK_BL_ACT:
                        cfg_bl_act = cfg_data[oplbp_pkg::ACTION_W-1:0];
                    default: ;
                endcase
            end

            // the result leaving now always belongs to an older item
            if (out_valid && out_ready)
            begin
                got = {pin_level, switch_write, switch_value, blink_write, blink_value,
                       status_write, status_value};
                if (pending_pin_results.size() == 0)
                    note_mismatch($sformatf("result %b with no item waiting", got));
                else
                begin
                    want = pending_pin_results.pop_front();
                    for (int b = 6; b >= 0; b--)
                        if (got[b] !== want[b])
                            note_mismatch($sformatf("%s got %b expected %b",
                                                    field_names[b], got[b], want[b]));
                end
            end

            if (in_valid && in_ready)
                pending_pin_results.push_back(step_pin_driver(event_kind, obj_value, now_ms));

            outstanding = pending_pin_results.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus, register programming and verdict for output_pin_lock_blink_pulse
// depends on oplbp_pkg, the block itself and tb_pin_checker
module tb_top;

    localparam int  IDLE_PCT        = 11;
    localparam int  PHASES          = 12;
    localparam int  ITEMS_PER_PHASE = 90;
    localparam int  HOLD_PHASE      = 3;
    localparam int  STEADY_PHASE    = 5;
    localparam int  PAUSE_PHASE     = 7;
    localparam int  HOLD_CYCLES     = 80;
    localparam int  SETTLE_CYCLES   = 8;
    localparam time TIMEOUT_NS      = 2_000_000;

    // first register index that the block does not implement
    localparam logic [oplbp_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [oplbp_pkg::KIND_W-1:0]    event_kind;
    logic                            obj_value;
    logic [oplbp_pkg::TIME_W-1:0]    now_ms;
    logic                            out_valid;
    logic                            out_ready;
    logic                            pin_level;
    logic                            switch_write;
    logic                            switch_value;
    logic                            blink_write;
    logic                            blink_value;
    logic                            status_write;
    logic                            status_value;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [oplbp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [oplbp_pkg::CFG_DAT_W-1:0] cfg_data;

    int                              mismatch_count;
    int                              outstanding;

    bit                              steady;
    bit                              hold_req;
    logic [oplbp_pkg::TIME_W-1:0]    clock_ms;

    output_pin_lock_blink_pulse u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .event_kind   (event_kind),
        .obj_value    (obj_value),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pin_level    (pin_level),
        .switch_write (switch_write),
        .switch_value (switch_value),
        .blink_write  (blink_write),
        .blink_value  (blink_value),
        .status_write (status_write),
        .status_value (status_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tb_pin_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .event_kind     (event_kind),
        .obj_value      (obj_value),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pin_level      (pin_level),
        .switch_write   (switch_write),
        .switch_value   (switch_value),
        .blink_write    (blink_write),
        .blink_value    (blink_value),
        .status_write   (status_write),
        .status_value   (status_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls, a counted hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_item(input logic [oplbp_pkg::KIND_W-1:0] kind, input logic val,
                             input logic [oplbp_pkg::TIME_W-1:0] now);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        event_kind <= kind;
        obj_value  <= val;
        now_ms     <= now;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop offering items and wait for every result to come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [oplbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [oplbp_pkg::CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random bits above the register width, which the block must drop
    function automatic logic [oplbp_pkg::CFG_DAT_W-1:0] with_noise(
        input logic [oplbp_pkg::CFG_DAT_W-1:0] v, input int w);
        logic [oplbp_pkg::CFG_DAT_W-1:0] keep;
        keep = (oplbp_pkg::CFG_DAT_W'(1) << w) - oplbp_pkg::CFG_DAT_W'(1);
        return (oplbp_pkg::CFG_DAT_W'($urandom) & ~keep) | (v & keep);
    endfunction

    function automatic logic [oplbp_pkg::ON_OFF_W-1:0] pick_ms(input int sel);
        case (sel % 4)
            0:       return oplbp_pkg::ON_OFF_W'($urandom_range(0, 15));
            1:       return '1;
            2:       return '0;
            default: return oplbp_pkg::ON_OFF_W'($urandom);
        endcase
    endfunction

    task automatic program_phase(input int p);
        logic [oplbp_pkg::ACTION_W-1:0] sw_act;
        logic [oplbp_pkg::ACTION_W-1:0] bl_act;
        sw_act = oplbp_pkg::ACTION_W'(p % 4);
        bl_act = oplbp_pkg::ACTION_W'((3 * p + 1) % 4);
        write_reg(oplbp_pkg::REG_BLINK_MODE,
                  with_noise(oplbp_pkg::CFG_DAT_W'(p % 8), oplbp_pkg::MODE_W));
        write_reg(oplbp_pkg::REG_ON_TIME, pick_ms(p));
        write_reg(oplbp_pkg::REG_OFF_TIME, pick_ms(p + 1));
        write_reg(oplbp_pkg::REG_INVERT_OUT, with_noise(oplbp_pkg::CFG_DAT_W'(p & 1), 1));
        write_reg(oplbp_pkg::REG_LOCK_INVERT,
                  with_noise(oplbp_pkg::CFG_DAT_W'((p >> 1) & 1), 1));
        write_reg(oplbp_pkg::REG_LOCK_RESUME,
                  with_noise(oplbp_pkg::CFG_DAT_W'((p >> 2) & 1), 1));
        write_reg(oplbp_pkg::REG_LOCK_SW_ACT,
                  with_noise(oplbp_pkg::CFG_DAT_W'(sw_act), oplbp_pkg::ACTION_W));
        write_reg(oplbp_pkg::REG_LOCK_BL_ACT,
                  with_noise(oplbp_pkg::CFG_DAT_W'(bl_act), oplbp_pkg::ACTION_W));
        write_reg(REG_FIRST_UNUSED + oplbp_pkg::CFG_IDX_W'(p % 8),
                  oplbp_pkg::CFG_DAT_W'($urandom));
        // some phases run across the wrap of the millisecond counter
        if (p % 3 == 0)
            clock_ms = oplbp_pkg::TIMER_IDLE - oplbp_pkg::TIME_W'($urandom_range(0, 300));
        else
            clock_ms = $urandom;
    endtask

    task automatic send_random_item();
        int                           roll;
        logic [oplbp_pkg::KIND_W-1:0] kind;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            kind = oplbp_pkg::EV_TICK;
        else if (roll < 6)
            kind = oplbp_pkg::EV_SWITCH;
        else if (roll < 8)
            kind = oplbp_pkg::EV_BLINK;
        else
            kind = oplbp_pkg::EV_LOCK;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            clock_ms = clock_ms + $urandom_range(0, 12);
        else if (roll < 92)
            clock_ms = clock_ms + $urandom_range(0, 2000);
        else if (roll < 98)
            clock_ms = clock_ms + $urandom_range(0, 70000);
        else
            clock_ms = $urandom;
        send_item(kind, 1'($urandom_range(0, 1)), clock_ms);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        event_kind = oplbp_pkg::EV_TICK;
        obj_value  = 1'b0;
        now_ms     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = oplbp_pkg::REG_BLINK_MODE;
        cfg_data   = '0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        clock_ms   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: plain switch following, lock without actions
        send_item(oplbp_pkg::EV_TICK, 1'b1, '0);
        send_item(oplbp_pkg::EV_SWITCH, 1'b1, '1);
        send_item(oplbp_pkg::EV_BLINK, 1'b1, 32'd5);
        send_item(oplbp_pkg::EV_LOCK, 1'b1, 32'd6);
        send_item(oplbp_pkg::EV_SWITCH, 1'b0, 32'd7);
        send_item(oplbp_pkg::EV_LOCK, 1'b0, 32'd8);
        send_item(oplbp_pkg::EV_SWITCH, 1'b0, 32'd9);
        send_item(oplbp_pkg::EV_TICK, 1'b0, 32'd10);
        drain();

        // pulse mode with lock forcing the switch on and toggling blink
        write_reg(oplbp_pkg::REG_BLINK_MODE, 16'hFFFF);
        write_reg(oplbp_pkg::REG_ON_TIME, 16'd10);
        write_reg(oplbp_pkg::REG_LOCK_SW_ACT,
                  with_noise(oplbp_pkg::CFG_DAT_W'(oplbp_pkg::ACT_ON), oplbp_pkg::ACTION_W));
        write_reg(oplbp_pkg::REG_LOCK_BL_ACT, oplbp_pkg::CFG_DAT_W'(oplbp_pkg::ACT_TOGGLE));
        write_reg(oplbp_pkg::REG_LOCK_RESUME, 16'd1);
        write_reg(oplbp_pkg::REG_INVERT_OUT, 16'd1);
        write_reg(REG_FIRST_UNUSED + 4'd1, 16'hFFFF);
        send_item(oplbp_pkg::EV_SWITCH, 1'b1, 32'd100);
        send_item(oplbp_pkg::EV_TICK, 1'b0, 32'd105);
        send_item(oplbp_pkg::EV_TICK, 1'b0, 32'd111);
        // pulse expires while the switch is off, then a later switch on ends it
        send_item(oplbp_pkg::EV_SWITCH, 1'b1, 32'd200);
        send_item(oplbp_pkg::EV_SWITCH, 1'b0, 32'd205);
        send_item(oplbp_pkg::EV_TICK, 1'b0, 32'd300);
        send_item(oplbp_pkg::EV_SWITCH, 1'b1, 32'd301);
        // lock action and pulse end both rewrite the switch in one item
        send_item(oplbp_pkg::EV_SWITCH, 1'b1, 32'd400);
        send_item(oplbp_pkg::EV_LOCK, 1'b1, 32'd420);
        send_item(oplbp_pkg::EV_SWITCH, 1'b1, 32'd430);
        send_item(oplbp_pkg::EV_LOCK, 1'b0, 32'd431);
        // pulse end sum landing exactly on the idle value
        send_item(oplbp_pkg::EV_SWITCH, 1'b1, 32'hFFFF_FFF5);
        send_item(oplbp_pkg::EV_SWITCH, 1'b1, 32'hFFFF_FFF5);
        send_item(oplbp_pkg::EV_TICK, 1'b0, '0);
        drain();

        // blinking always, with a late tick that may advance only one phase
        write_reg(oplbp_pkg::REG_BLINK_MODE, oplbp_pkg::CFG_DAT_W'(oplbp_pkg::MODE_ALWAYS));
        write_reg(oplbp_pkg::REG_ON_TIME, 16'd5);
        write_reg(oplbp_pkg::REG_OFF_TIME, 16'd5);
        write_reg(oplbp_pkg::REG_INVERT_OUT, 16'd0);
        send_item(oplbp_pkg::EV_TICK, 1'b0, 32'd1000);
        send_item(oplbp_pkg::EV_TICK, 1'b0, 32'd5000);
        send_item(oplbp_pkg::EV_TICK, 1'b0, 32'd5006);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            program_phase(p);
            steady = (p == STEADY_PHASE);
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2)
                    drain();
                send_random_item();
            end
            drain();
            steady = 1'b0;
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
